// File: hw/rtl/epx_pkg.sv
// ============================================================================
// epx_pkg
// Shared types, field widths, weights and register map of the EPX 2x upscaler.
// ============================================================================
package epx_pkg;

    // Default frame limits
    localparam int MAX_WIDTH_DFLT  = 2048;
    localparam int MAX_HEIGHT_DFLT = 4096;

    // Field widths
    localparam int PIX_W     = 32;
    localparam int CH_W      = 8;
    localparam int NUM_CH    = 3;
    localparam int FW_W      = 12;
    localparam int FH_W      = 13;
    localparam int TH_W      = 9;
    localparam int COL_OUT_W = 11;
    localparam int ROW_OUT_W = 12;
    localparam int DIST_W    = 18;   // 1000 * 255 fits
    localparam int THRK_W    = 19;   // 511 * 1000 fits

    // Color channel order inside a pixel, lowest byte first
    localparam int CH_B = 0;
    localparam int CH_G = 1;
    localparam int CH_R = 2;

    // Luma weights of the color distance
    localparam int WT_R      = 299;
    localparam int WT_G      = 587;
    localparam int WT_B      = 114;
    localparam int THR_SCALE = 1000;

    // Neighbor pairs that are compared
    localparam int NUM_PAIR = 4;
    localparam int PAIR_CA  = 0;
    localparam int PAIR_AB  = 1;
    localparam int PAIR_BD  = 2;
    localparam int PAIR_DC  = 3;

    // Register map
    localparam int PADDR_W   = 4;
    localparam int REG_IDX_W = 2;
    localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH     = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT    = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_COMPARE_MODE    = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_COLOR_THRESHOLD = 2'd3;

    localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 12'd640;
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 13'd480;

    typedef logic [PIX_W-1:0]             t_pix;
    typedef logic [NUM_CH-1:0][CH_W-1:0]  t_rgb;

    // Neighborhood of one source pixel
    typedef struct packed {
        t_pix p;
        t_pix a;
        t_pix b;
        t_pix c;
        t_pix d;
    } t_win;

    // Position and frame tag of one output block
    typedef struct packed {
        logic [COL_OUT_W-1:0] col;
        logic [ROW_OUT_W-1:0] row;
        logic                 last;
    } t_meta;

    // Per-channel absolute difference of the RGB bytes, alpha ignored
    function automatic t_rgb rgb_absdiff(t_pix x, t_pix y);
        t_rgb d;
        logic [CH_W-1:0] xc;
        logic [CH_W-1:0] yc;
        for (int ch = 0; ch < NUM_CH; ch++) begin
            xc    = x[ch*CH_W +: CH_W];
            yc    = y[ch*CH_W +: CH_W];
            d[ch] = (xc > yc) ? (xc - yc) : (yc - xc);
        end
        return d;
    endfunction

    // Luma-weighted sum of channel differences
    function automatic logic [DIST_W-1:0] rgb_dist(t_rgb d);
        return DIST_W'(WT_R) * DIST_W'(d[CH_R])
             + DIST_W'(WT_G) * DIST_W'(d[CH_G])
             + DIST_W'(WT_B) * DIST_W'(d[CH_B]);
    endfunction

endpackage

// File: hw/rtl/epx_pix_if.sv
// ============================================================================
// epx_pix_if
// Source pixel stream: valid/ready handshake with one ARGB pixel per beat.
// ============================================================================
interface epx_pix_if;
    logic               valid;
    logic               ready;
    epx_pkg::t_pix      pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

// File: hw/rtl/epx_blk_if.sv
// ============================================================================
// epx_blk_if
// Output block stream: one 2x2 upscaled block and its source position per beat.
// ============================================================================
interface epx_blk_if;
    logic                               valid;
    logic                               ready;
    epx_pkg::t_pix                      out_top_left;
    epx_pkg::t_pix                      out_top_right;
    epx_pkg::t_pix                      out_bottom_left;
    epx_pkg::t_pix                      out_bottom_right;
    logic [epx_pkg::COL_OUT_W-1:0]      center_col;
    logic [epx_pkg::ROW_OUT_W-1:0]      center_row;
    logic                               frame_last;

    modport source (
        output valid, output out_top_left, output out_top_right,
        output out_bottom_left, output out_bottom_right,
        output center_col, output center_row, output frame_last,
        input  ready
    );
    modport sink (
        input  valid, input out_top_left, input out_top_right,
        input  out_bottom_left, input out_bottom_right,
        input  center_col, input center_row, input frame_last,
        output ready
    );
endinterface

// File: hw/rtl/epx_lstore.sv
// ============================================================================
// epx_lstore
// Two-row pixel line store, one bank per row parity. Each bank is read at the
// current column and the next one; the read data is registered.
// ============================================================================
module epx_lstore #(
    parameter int MAX_WIDTH = epx_pkg::MAX_WIDTH_DFLT
) (
    input  logic                         i_clk,
    input  logic                         i_wr_en,
    input  logic                         i_rd_en,
    input  logic                         i_row_bank,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_addr,
    input  epx_pkg::t_pix                i_wr_data,
    output epx_pkg::t_pix                o_p,
    output epx_pkg::t_pix                o_a,
    output epx_pkg::t_pix                o_b
);

    localparam int AW = $clog2(MAX_WIDTH);

    epx_pkg::t_pix r_mem_even [MAX_WIDTH];
    epx_pkg::t_pix r_mem_odd  [MAX_WIDTH];

    epx_pkg::t_pix r_even_cur;
    epx_pkg::t_pix r_even_nxt;
    epx_pkg::t_pix r_odd_cur;
    epx_pkg::t_pix r_odd_nxt;
    logic          r_bank;
    logic [AW-1:0] addr_nxt;

    assign addr_nxt = i_addr + AW'(1);

    // Write the current row bank; read both banks at this column and the next
    always_ff @(posedge i_clk) begin
        if (i_wr_en && !i_row_bank) begin
            r_mem_even[i_addr] <= i_wr_data;
        end
        if (i_wr_en && i_row_bank) begin
            r_mem_odd[i_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_even_cur <= r_mem_even[i_addr];
            r_even_nxt <= r_mem_even[addr_nxt];
            r_odd_cur  <= r_mem_odd[i_addr];
            r_odd_nxt  <= r_mem_odd[addr_nxt];
            r_bank     <= i_row_bank;
        end
    end

    // Row above comes from the other bank, two rows above from this bank
    assign o_p = r_bank ? r_even_cur : r_odd_cur;
    assign o_b = r_bank ? r_even_nxt : r_odd_nxt;
    assign o_a = r_bank ? r_odd_cur  : r_even_cur;

endmodule

// File: hw/rtl/epx_2x_pixel_upscale_unit.sv
// ============================================================================
// epx_2x_pixel_upscale_unit
// Streaming Scale2x/EPX upscaler: one 2x2 output block per source pixel.
// ============================================================================
// Usage: send a frame of ARGB pixels in raster order, then frame_width drain
// beats whose pixel is ignored. Row 0 produces no blocks; every later row and
// the drain row each produce the blocks of the row above, one block per input
// beat, so output lags input by one source row. The unit takes one pixel per
// clock cycle while the output is not stalled; each beat passes stage 1 with
// the line store read, stages 2 to 4 and the output register. That rate comes
// from the two-bank line store, whose two read ports deliver the center, up and
// right neighbors of a pixel in a single access, with the left neighbor kept
// from the previous pixel. The line store has no reset and needs no clearing
// pass. Program the registers only while no block is in flight.
// ============================================================================
module epx_2x_pixel_upscale_unit #(
    parameter int MAX_WIDTH  = epx_pkg::MAX_WIDTH_DFLT,
    parameter int MAX_HEIGHT = epx_pkg::MAX_HEIGHT_DFLT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    epx_pix_if.sink                       i_pix,
    epx_blk_if.source                     o_blk,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [epx_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int WCNT_W = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W  = $clog2(MAX_HEIGHT + 1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [epx_pkg::FW_W-1:0]      r_frame_width;
    logic [epx_pkg::FH_W-1:0]      r_frame_height;
    logic                          r_compare_mode;
    logic [epx_pkg::TH_W-1:0]      r_color_threshold;
    logic                          cfg_wr;
    logic [epx_pkg::REG_IDX_W-1:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[epx_pkg::PADDR_W-1:2];

    // Write the addressed register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width     <= epx_pkg::FRAME_WIDTH_RST;
            r_frame_height    <= epx_pkg::FRAME_HEIGHT_RST;
            r_compare_mode    <= 1'b0;
            r_color_threshold <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                epx_pkg::REG_FRAME_WIDTH: begin
                    r_frame_width <= pwdata[epx_pkg::FW_W-1:0];
                end
                epx_pkg::REG_FRAME_HEIGHT: begin
                    r_frame_height <= pwdata[epx_pkg::FH_W-1:0];
                end
                epx_pkg::REG_COMPARE_MODE: begin
                    r_compare_mode <= pwdata[0];
                end
                epx_pkg::REG_COLOR_THRESHOLD: begin
                    r_color_threshold <= pwdata[epx_pkg::TH_W-1:0];
                end
            endcase
        end
    end

    // Read back the addressed register
    always_comb begin
        unique case (cfg_idx)
            epx_pkg::REG_FRAME_WIDTH:     prdata = 32'(r_frame_width);
            epx_pkg::REG_FRAME_HEIGHT:    prdata = 32'(r_frame_height);
            epx_pkg::REG_COMPARE_MODE:    prdata = 32'(r_compare_mode);
            epx_pkg::REG_COLOR_THRESHOLD: prdata = 32'(r_color_threshold);
        endcase
    end

    // Clamp the frame size into the supported range
    logic [WCNT_W-1:0] w_eff;
    logic [ROW_W-1:0]  h_eff;

    always_comb begin
        if (r_frame_width == '0) begin
            w_eff = WCNT_W'(1);
        end else if (32'(r_frame_width) > 32'(MAX_WIDTH)) begin
            w_eff = WCNT_W'(MAX_WIDTH);
        end else begin
            w_eff = WCNT_W'(r_frame_width);
        end
        if (r_frame_height == '0) begin
            h_eff = ROW_W'(1);
        end else if (32'(r_frame_height) > 32'(MAX_HEIGHT)) begin
            h_eff = ROW_W'(MAX_HEIGHT);
        end else begin
            h_eff = ROW_W'(r_frame_height);
        end
    end

    // ------------------------------------------------------------------
    // Stage enables: a stage loads when it is empty or its successor loads
    // ------------------------------------------------------------------
    logic r_s1_v, r_s2_v, r_s3_v, r_s4_v, r_o_v;
    logic en1, en2, en3, en4, en_out;

    assign en_out = !r_o_v  || o_blk.ready;
    assign en4    = !r_s4_v || en_out;
    assign en3    = !r_s3_v || en4;
    assign en2    = !r_s2_v || en3;
    assign en1    = !r_s1_v || en2;

    // ------------------------------------------------------------------
    // Input position and line store access
    // ------------------------------------------------------------------
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic             accept;
    logic             col_last;
    logic             drain;
    logic             emit;
    logic             frame_end;

    assign i_pix.ready = en1;
    assign accept      = i_pix.valid && en1;
    assign col_last    = (32'(r_col) + 32'd1) >= 32'(w_eff);
    assign drain       = 32'(r_row) >= 32'(h_eff);
    assign emit        = (r_row != '0) || drain;
    assign frame_end   = drain && (32'(r_row) == 32'(h_eff)) && col_last;

    // Advance column and row; drain row wraps back to the frame start
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            if (col_last) begin
                r_col <= '0;
                r_row <= drain ? '0 : r_row + ROW_W'(1);
            end else begin
                r_col <= r_col + COL_W'(1);
            end
        end
    end

    epx_pkg::t_pix mem_p;
    epx_pkg::t_pix mem_a;
    epx_pkg::t_pix mem_b;

    epx_lstore #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_lstore (
        .i_clk      (i_clk),
        .i_wr_en    (accept && !drain),
        .i_rd_en    (accept),
        .i_row_bank (r_row[0]),
        .i_addr     (r_col),
        .i_wr_data  (i_pix.pixel),
        .o_p        (mem_p),
        .o_a        (mem_a),
        .o_b        (mem_b)
    );

    // ------------------------------------------------------------------
    // Pipeline payload
    // ------------------------------------------------------------------
    epx_pkg::t_pix   r_s1_d;
    epx_pkg::t_meta  r_s1_meta;
    logic            r_s1_xfirst;
    logic            r_s1_xlast;
    logic            r_s1_yfirst;
    logic            r_s1_drain;
    epx_pkg::t_pix   r_prev_p;

    epx_pkg::t_win   n_s2_win;
    epx_pkg::t_win   r_s2_win;
    epx_pkg::t_meta  r_s2_meta;

    epx_pkg::t_pix   pair_lhs [epx_pkg::NUM_PAIR];
    epx_pkg::t_pix   pair_rhs [epx_pkg::NUM_PAIR];
    logic [epx_pkg::NUM_PAIR-1:0] n_s3_eq;
    epx_pkg::t_rgb   n_s3_diff [epx_pkg::NUM_PAIR];
    epx_pkg::t_win   r_s3_win;
    epx_pkg::t_meta  r_s3_meta;
    logic [epx_pkg::NUM_PAIR-1:0] r_s3_eq;
    epx_pkg::t_rgb   r_s3_diff [epx_pkg::NUM_PAIR];

    logic [epx_pkg::DIST_W-1:0] n_s4_dist [epx_pkg::NUM_PAIR];
    epx_pkg::t_win   r_s4_win;
    epx_pkg::t_meta  r_s4_meta;
    logic [epx_pkg::NUM_PAIR-1:0] r_s4_eq;
    logic [epx_pkg::DIST_W-1:0] r_s4_dist [epx_pkg::NUM_PAIR];

    logic [epx_pkg::THRK_W-1:0]   thr_k;
    logic [epx_pkg::NUM_PAIR-1:0] m;
    epx_pkg::t_pix   r_o_tl, r_o_tr, r_o_bl, r_o_br;
    epx_pkg::t_meta  r_o_meta;

    // Valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
            r_o_v  <= 1'b0;
        end else begin
            if (en1)    r_s1_v <= accept && emit;
            if (en2)    r_s2_v <= r_s1_v;
            if (en3)    r_s3_v <= r_s2_v;
            if (en4)    r_s4_v <= r_s3_v;
            if (en_out) r_o_v  <= r_s4_v;
        end
    end

    // Stage 1: capture the down pixel and the position flags
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_d        <= i_pix.pixel;
            r_s1_meta.col <= epx_pkg::COL_OUT_W'(r_col);
            r_s1_meta.row <= epx_pkg::ROW_OUT_W'(r_row - ROW_W'(1));
            r_s1_meta.last <= frame_end;
            r_s1_xfirst   <= (r_col == '0);
            r_s1_xlast    <= col_last;
            r_s1_yfirst   <= (r_row == ROW_W'(1));
            r_s1_drain    <= drain;
        end
    end

    // Clamp neighbors outside the frame to the center pixel
    always_comb begin
        n_s2_win.p = mem_p;
        n_s2_win.a = r_s1_yfirst ? mem_p : mem_a;
        n_s2_win.b = r_s1_xlast  ? mem_p : mem_b;
        n_s2_win.c = r_s1_xfirst ? mem_p : r_prev_p;
        n_s2_win.d = r_s1_drain  ? mem_p : r_s1_d;
    end

    // Stage 2: hold the window; keep this center as the next left neighbor
    always_ff @(posedge i_clk) begin
        if (en2 && r_s1_v) begin
            r_s2_win  <= n_s2_win;
            r_s2_meta <= r_s1_meta;
            r_prev_p  <= mem_p;
        end
    end

    // Exact compare and per-channel differences of each pair
    always_comb begin
        pair_lhs[epx_pkg::PAIR_CA] = r_s2_win.c;
        pair_rhs[epx_pkg::PAIR_CA] = r_s2_win.a;
        pair_lhs[epx_pkg::PAIR_AB] = r_s2_win.a;
        pair_rhs[epx_pkg::PAIR_AB] = r_s2_win.b;
        pair_lhs[epx_pkg::PAIR_BD] = r_s2_win.b;
        pair_rhs[epx_pkg::PAIR_BD] = r_s2_win.d;
        pair_lhs[epx_pkg::PAIR_DC] = r_s2_win.d;
        pair_rhs[epx_pkg::PAIR_DC] = r_s2_win.c;
        for (int i = 0; i < epx_pkg::NUM_PAIR; i++) begin
            n_s3_eq[i]   = (pair_lhs[i] == pair_rhs[i]);
            n_s3_diff[i] = epx_pkg::rgb_absdiff(pair_lhs[i], pair_rhs[i]);
        end
    end

    // Stage 3
    always_ff @(posedge i_clk) begin
        if (en3 && r_s2_v) begin
            r_s3_win  <= r_s2_win;
            r_s3_meta <= r_s2_meta;
            r_s3_eq   <= n_s3_eq;
            r_s3_diff <= n_s3_diff;
        end
    end

    // Weighted color distance of each pair
    always_comb begin
        for (int i = 0; i < epx_pkg::NUM_PAIR; i++) begin
            n_s4_dist[i] = epx_pkg::rgb_dist(r_s3_diff[i]);
        end
    end

    // Stage 4
    always_ff @(posedge i_clk) begin
        if (en4 && r_s3_v) begin
            r_s4_win  <= r_s3_win;
            r_s4_meta <= r_s3_meta;
            r_s4_eq   <= r_s3_eq;
            r_s4_dist <= n_s4_dist;
        end
    end

    // Resolve matches in the selected mode
    assign thr_k = epx_pkg::THRK_W'(r_color_threshold) * epx_pkg::THRK_W'(epx_pkg::THR_SCALE);

    always_comb begin
        for (int i = 0; i < epx_pkg::NUM_PAIR; i++) begin
            m[i] = r_compare_mode ? (epx_pkg::THRK_W'(r_s4_dist[i]) < thr_k) : r_s4_eq[i];
        end
    end

    // Output register: pick each quadrant from its neighbor or the center
    always_ff @(posedge i_clk) begin
        if (en_out && r_s4_v) begin
            r_o_tl <= (m[epx_pkg::PAIR_CA] && !m[epx_pkg::PAIR_DC] && !m[epx_pkg::PAIR_AB])
                      ? r_s4_win.a : r_s4_win.p;
            r_o_tr <= (m[epx_pkg::PAIR_AB] && !m[epx_pkg::PAIR_CA] && !m[epx_pkg::PAIR_BD])
                      ? r_s4_win.b : r_s4_win.p;
            r_o_bl <= (m[epx_pkg::PAIR_DC] && !m[epx_pkg::PAIR_BD] && !m[epx_pkg::PAIR_CA])
                      ? r_s4_win.c : r_s4_win.p;
            r_o_br <= (m[epx_pkg::PAIR_BD] && !m[epx_pkg::PAIR_AB] && !m[epx_pkg::PAIR_DC])
                      ? r_s4_win.d : r_s4_win.p;
            r_o_meta <= r_s4_meta;
        end
    end

    assign o_blk.valid            = r_o_v;
    assign o_blk.out_top_left     = r_o_tl;
    assign o_blk.out_top_right    = r_o_tr;
    assign o_blk.out_bottom_left  = r_o_bl;
    assign o_blk.out_bottom_right = r_o_br;
    assign o_blk.center_col       = r_o_meta.col;
    assign o_blk.center_row       = r_o_meta.row;
    assign o_blk.frame_last       = r_o_meta.last;

`ifndef ASSERT_OFF
    // A stalled stage 1 item keeps its line store read data: no new read starts
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_v && !en2) |-> !accept)
        else $error("line store read started under a stalled item");

    // First-row pixels are stored but never start a block
    a_row0_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (r_row == '0) && !drain) |=> !r_s1_v)
        else $error("first-row pixel produced a block");

    // Reset empties the pipeline
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_s1_v && !r_s4_v && !r_o_v))
        else $error("pipeline not empty after reset");
`endif

endmodule
